// File: rtl/corner_kernel_gap_score_core_assert.svh
// assertion macros shared by the corner scorer rtl
`ifndef CORNER_KERNEL_GAP_SCORE_CORE_ASSERT_SVH
`define CORNER_KERNEL_GAP_SCORE_CORE_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define CKGS_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define CKGS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ckgs_pkg.sv
`default_nettype none

package ckgs_pkg;

	// default sizes of the line buffer and window
	localparam int DEF_MAX_IMAGE_WIDTH = 4096;
	localparam int DEF_MAX_KERNEL_ROWS = 32;
	localparam int DEF_MAX_KERNEL_COLS = 32;

	// largest frame height in rows
	localparam int MAX_HEIGHT = 4096;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 13;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KERNEL_ROWS  = 3'd0,
		REG_KERNEL_COLS  = 3'd1,
		REG_MAX_GAPS     = 3'd2,
		REG_IMAGE_WIDTH  = 3'd3,
		REG_IMAGE_HEIGHT = 3'd4
	} cfg_reg_t;

	// register values after reset
	localparam logic [5:0]  RST_KERNEL_ROWS  = 6'd8;
	localparam logic [5:0]  RST_KERNEL_COLS  = 6'd8;
	localparam logic [5:0]  RST_MAX_GAPS     = 6'd2;
	localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd1024;
	localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd768;

	// one pixel in
	typedef struct packed {
		logic is_edge;
		logic frame_start;
	} in_item_t;

	// one window score out
	typedef struct packed {
		logic [11:0] anchor_row;
		logic [11:0] anchor_col;
		logic [5:0]  left_score;
		logic [5:0]  right_score;
		logic        frame_last;
	} out_item_t;

endpackage

`default_nettype wire

// File: rtl/corner_kernel_gap_score_core.sv
// corner kernel gap scorer
// in_valid/in_stall carries one binary edge pixel per item in raster order;
// frame_start on a pixel restarts the row and column count at that pixel.
// out_valid/out_stall carries one item per window whose bottom-right pixel
// has just arrived: anchor position, top-left and top-right corner scores,
// and frame_last on the final window of the frame. pixels that complete no
// window produce nothing.
// configuration goes through cfg_write/cfg_index/cfg_data, only while idle.
// a pixel goes through the input register, then the result register, before
// its result is presented on out_data.
// throughput: one pixel per cycle while in_stall is low, set by the column
// line buffer, which takes one read and one write of a column word per cycle.
// a stalled output holds its item; one more pixel is accepted behind it and
// in_stall rises only when that pixel also completes a window.
// reset clears the counters, the window and the pipeline valids and loads the
// register defaults; the line buffer is not cleared and fills with the first
// kernel_rows rows of the first frame.
`default_nettype none

`include "corner_kernel_gap_score_core_assert.svh"

module corner_kernel_gap_score_core #(
	parameter int MAX_IMAGE_WIDTH = ckgs_pkg::DEF_MAX_IMAGE_WIDTH,
	parameter int MAX_KERNEL_ROWS = ckgs_pkg::DEF_MAX_KERNEL_ROWS,
	parameter int MAX_KERNEL_COLS = ckgs_pkg::DEF_MAX_KERNEL_COLS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [ckgs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ckgs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire ckgs_pkg::in_item_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output ckgs_pkg::out_item_t                  out_data
);
	import ckgs_pkg::*;

	localparam int CW  = $clog2(MAX_IMAGE_WIDTH);
	localparam int RIW = $clog2(MAX_KERNEL_ROWS);
	localparam int CIW = $clog2(MAX_KERNEL_COLS);

	// configuration registers
	logic [5:0]  kernel_rows_q, kernel_cols_q, max_gaps_q;
	logic [12:0] image_width_q, image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_rows_q  <= RST_KERNEL_ROWS;
			kernel_cols_q  <= RST_KERNEL_COLS;
			max_gaps_q     <= RST_MAX_GAPS;
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KERNEL_ROWS:  kernel_rows_q  <= cfg_data[5:0];
				REG_KERNEL_COLS:  kernel_cols_q  <= cfg_data[5:0];
				REG_MAX_GAPS:     max_gaps_q     <= cfg_data[5:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped sizes
	logic [7:0]  kr_c, kc_c;
	logic [15:0] w_c, h_c;

	always_comb begin
		kr_c = 8'(kernel_rows_q);
		if (kr_c < 8'd2)
			kr_c = 8'd2;
		else if (kr_c > 8'(MAX_KERNEL_ROWS))
			kr_c = 8'(MAX_KERNEL_ROWS);
		kc_c = 8'(kernel_cols_q);
		if (kc_c < 8'd2)
			kc_c = 8'd2;
		else if (kc_c > 8'(MAX_KERNEL_COLS))
			kc_c = 8'(MAX_KERNEL_COLS);
		w_c = 16'(image_width_q);
		if (w_c < 16'd2)
			w_c = 16'd2;
		else if (w_c > 16'(MAX_IMAGE_WIDTH))
			w_c = 16'(MAX_IMAGE_WIDTH);
		h_c = 16'(image_height_q);
		if (h_c < 16'd2)
			h_c = 16'd2;
		else if (h_c > 16'(MAX_HEIGHT))
			h_c = 16'(MAX_HEIGHT);
	end

	// handshake and pipeline control
	logic valid_s1, emit_s1, adv_s1, in_acc;

	assign adv_s1   = valid_s1 && (!emit_s1 || !out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	// pixel position for the incoming item
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic [15:0]   c_in, r_in, c_inc, r_inc;
	logic [CW-1:0] c_idx;
	logic          emit_in, last_in;
	logic [11:0]   anchor_row_in, anchor_col_in;

	always_comb begin
		c_in = in_data.frame_start ? 16'd0 : 16'(col_q);
		r_in = in_data.frame_start ? 16'd0 : 16'(row_q);
		if (c_in >= w_c) begin
			c_in = 16'd0;
			r_in = r_in + 16'd1;
		end
		if (r_in >= h_c)
			r_in = 16'd0;
		c_idx         = CW'(c_in);
		c_inc         = c_in + 16'd1;
		r_inc         = r_in + 16'd1;
		emit_in       = (r_inc >= 16'(kr_c)) && (c_inc >= 16'(kc_c));
		anchor_row_in = 12'(r_inc - 16'(kr_c));
		anchor_col_in = 12'(c_inc - 16'(kc_c));
		last_in       = (r_inc == h_c) && (c_inc == w_c);
	end

	// row and column counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (c_inc >= w_c) begin
				col_q <= '0;
				row_q <= (r_inc >= h_c) ? 12'd0 : 12'(r_inc);
			end else begin
				col_q <= CW'(c_inc);
				row_q <= 12'(r_in);
			end
		end
	end

	// stage 1 control
	logic          byp_s1;
	logic [CW-1:0] c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			byp_s1   <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			emit_s1  <= emit_in;
			byp_s1   <= valid_s1 && (c_s1 == c_idx);
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end
	end

	// stage 1 payload
	logic                       edge_s1, last_s1;
	logic [11:0]                anchor_row_s1, anchor_col_s1;
	logic [MAX_KERNEL_ROWS-1:0] byp_word_s1, hist_s1, word;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			edge_s1       <= in_data.is_edge;
			last_s1       <= last_in;
			c_s1          <= c_idx;
			anchor_row_s1 <= anchor_row_in;
			anchor_col_s1 <= anchor_col_in;
			byp_word_s1   <= word;
		end
	end

	// column line buffer, one word per image column, newest row in bit 0
	logic [MAX_KERNEL_ROWS-1:0] col_mem [MAX_IMAGE_WIDTH];

	always_ff @(posedge clk) begin
		if (adv_s1)
			col_mem[c_s1] <= word;
		if (in_acc)
			hist_s1 <= col_mem[c_idx];
	end

	// back-to-back pixels in one column take the word still being written
	assign word = {(byp_s1 ? byp_word_s1[MAX_KERNEL_ROWS-2:0] : hist_s1[MAX_KERNEL_ROWS-2:0]),
		edge_s1};

	// window of recent column words, entry k is k+1 columns left
	logic [MAX_KERNEL_ROWS-1:0] window_q [MAX_KERNEL_COLS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_KERNEL_COLS - 1; k++)
				window_q[k] <= '0;
		end else if (adv_s1) begin
			window_q[0] <= word;
			for (int k = 1; k < MAX_KERNEL_COLS - 1; k++)
				window_q[k] <= window_q[k-1];
		end
	end

	// zero counts over the two corner shapes
	logic [MAX_KERNEL_ROWS-1:0] win [MAX_KERNEL_COLS];
	logic [RIW-1:0]             kr_m1;
	logic [CIW-1:0]             kc_m1;
	logic [MAX_KERNEL_ROWS-1:0] left_col;
	logic [MAX_KERNEL_COLS-1:0] top_bits;
	logic [MAX_KERNEL_ROWS-1:0] left_bits, right_bits;
	logic [7:0]                 top_z, left_z, right_z, left_miss, right_miss, total;
	logic [5:0]                 left_score, right_score;

	always_comb begin
		win[0] = word;
		for (int k = 1; k < MAX_KERNEL_COLS; k++)
			win[k] = window_q[k-1];
		kr_m1    = RIW'(kr_c - 8'd1);
		kc_m1    = CIW'(kc_c - 8'd1);
		left_col = win[kc_m1];
		// flag each missing pixel, then count the flags in parallel
		for (int k = 0; k < MAX_KERNEL_COLS; k++)
			top_bits[k] = (k <= int'(kc_m1)) && !win[k][kr_m1];
		for (int k = 0; k < MAX_KERNEL_ROWS; k++) begin
			left_bits[k]  = (k < int'(kr_m1)) && !left_col[k];
			right_bits[k] = (k < int'(kr_m1)) && !word[k];
		end
		top_z       = 8'($countones(top_bits));
		left_z      = 8'($countones(left_bits));
		right_z     = 8'($countones(right_bits));
		left_miss   = top_z + left_z;
		right_miss  = top_z + right_z;
		total       = kr_c + kc_c - 8'd1;
		left_score  = (left_miss > 8'(max_gaps_q)) ? 6'd0 : 6'(total - left_miss);
		right_score = (right_miss > 8'(max_gaps_q)) ? 6'd0 : 6'(total - right_miss);
	end

	// result register
	out_item_t out_data_q;
	logic      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && emit_s1)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			out_data_q.anchor_row  <= anchor_row_s1;
			out_data_q.anchor_col  <= anchor_col_s1;
			out_data_q.left_score  <= left_score;
			out_data_q.right_score <= right_score;
			out_data_q.frame_last  <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	`CKGS_ASSERT_SAME(a_stall_cause, in_stall,
		valid_s1 && emit_s1 && out_valid_q && out_stall, "input stalled without a blocked result")
	`CKGS_ASSERT_SAME(a_bypass_live, byp_s1, valid_s1, "column bypass set with stage 1 empty")
	`CKGS_ASSERT_NEXT(a_result_loaded, adv_s1 && emit_s1, out_valid_q,
		"completed window did not reach the result register")
	`CKGS_ASSERT_NEXT(a_result_drained, out_valid_q && !out_stall && !(adv_s1 && emit_s1),
		!out_valid_q, "taken result was presented again")

endmodule

`default_nettype wire

// File: tb/tb_corner_kernel_gap_score_core.sv
module tb_corner_kernel_gap_score_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ckgs_pkg::*;

	localparam int CYCLE_LIMIT   = 200_000;
	localparam int SETTLE_CYCLES = 4;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	// one line of the directed sequence
	typedef struct {
		row_kind_t             kind;
		cfg_reg_t              reg_id;
		logic [CFG_DATA_W-1:0] value;
		in_item_t              px;
		bit                    typed;
		out_item_t             want;
	} stim_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_item_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_data;

	// hand-typed expectation riding along with the pixel
	logic      px_typed = 1'b0;
	out_item_t px_want  = '0;
	bit        quiet    = 1'b0;

	// scorer model state
	logic [31:0] col_words [DEF_MAX_IMAGE_WIDTH];
	logic [31:0] win_words [DEF_MAX_KERNEL_COLS];
	int unsigned pix_row, pix_col;
	logic [5:0]  k_rows, k_cols, gap_limit;
	logic [12:0] img_w, img_h;

	out_item_t expected_scores [$];
	stim_row_t directed_rows [$];

	int mismatches  = 0;
	int pixels_in   = 0;
	int windows_out = 0;
	int phases      = 0;
	int cycle_count = 0;

	corner_kernel_gap_score_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned low_zeros(input logic [31:0] v, input int unsigned n);
		int unsigned z;
		z = 0;
		for (int k = 0; k < n; k++)
			if (!v[k]) z++;
		return z;
	endfunction

	function automatic logic [5:0] gap_score(input int unsigned miss, input int unsigned total);
		if (miss > gap_limit) return 6'd0;
		return 6'(total - miss);
	endfunction

	// place one pixel and score the window it completes, if any
	function automatic bit predict_window(input in_item_t px, output out_item_t res);
		int unsigned kr, kc, w, h, r, c, top, lmiss, rmiss, total;
		logic [31:0] word;
		bit hit;
		kr = clip(k_rows, 2, DEF_MAX_KERNEL_ROWS);
		kc = clip(k_cols, 2, DEF_MAX_KERNEL_COLS);
		w = clip(img_w, 2, DEF_MAX_IMAGE_WIDTH);
		h = clip(img_h, 2, MAX_HEIGHT);
		res = '0;
		hit = 1'b0;
		if (px.frame_start) begin
			pix_row = 0;
			pix_col = 0;
		end
		if (pix_col >= w) begin
			pix_col = 0;
			pix_row++;
		end
		if (pix_row >= h) pix_row = 0;
		r = pix_row;
		c = pix_col;

		// shift the new pixel into its column and the column into the window
		word = {col_words[c][30:0], px.is_edge};
		col_words[c] = word;
		for (int k = DEF_MAX_KERNEL_COLS - 1; k > 0; k--)
			win_words[k] = win_words[k-1];
		win_words[0] = word;

		// bottom-right pixel of a window that fits
		if (r + 1 >= kr && c + 1 >= kc) begin
			top = 0;
			for (int k = 0; k < kc; k++)
				if (!win_words[k][kr-1]) top++;
			lmiss = top + low_zeros(win_words[kc-1], kr - 1);
			rmiss = top + low_zeros(win_words[0], kr - 1);
			total = kr + kc - 1;
			res.anchor_row  = 12'(r + 1 - kr);
			res.anchor_col  = 12'(c + 1 - kc);
			res.left_score  = gap_score(lmiss, total);
			res.right_score = gap_score(rmiss, total);
			res.frame_last  = (r == h - 1 && c == w - 1);
			hit = 1'b1;
		end

		pix_col = c + 1;
		if (pix_col >= w) begin
			pix_col = 0;
			pix_row = r + 1;
			if (pix_row >= h) pix_row = 0;
		end
		return hit;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s got %0d want %0d",
				windows_out, name, got, want));
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_scores.size() == 0) begin
			report_mismatch($sformatf("unexpected result row %0d col %0d",
				got.anchor_row, got.anchor_col));
		end else begin
			want = expected_scores.pop_front();
			check_field("anchor_row", got.anchor_row, want.anchor_row);
			check_field("anchor_col", got.anchor_col, want.anchor_col);
			check_field("left_score", got.left_score, want.left_score);
			check_field("right_score", got.right_score, want.right_score);
			check_field("frame_last", got.frame_last, want.frame_last);
		end
		windows_out++;
	endtask

	// accepted items and register writes, seen at the rising edge
	always @(posedge clk) begin
		out_item_t pred;
		bit emits;
		if (arst_n) begin
			// results first so a pixel never meets its own expectation early
			if (out_valid && !out_stall) check_result(out_data);
			if (in_valid && !in_stall) begin
				emits = predict_window(in_data, pred);
				pixels_in++;
				if (px_typed) expected_scores.insert(expected_scores.size(), px_want);
				else if (emits) expected_scores.insert(expected_scores.size(), pred);
			end
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_KERNEL_ROWS:  k_rows = cfg_data[5:0];
					REG_KERNEL_COLS:  k_cols = cfg_data[5:0];
					REG_MAX_GAPS:     gap_limit = cfg_data[5:0];
					REG_IMAGE_WIDTH:  img_w = cfg_data;
					REG_IMAGE_HEIGHT: img_h = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_scores.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random stall before each item
	initial begin
		int unsigned hold;
		wait (arst_n);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 6);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_pixel(input in_item_t px, input bit typed, input out_item_t want);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= px;
		px_typed <= typed;
		px_want <= want;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending until every expected result is back
	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_scores.size() != 0) @(negedge clk);
	endtask

	// idle point for register writes: pixels that score nothing may still be in flight
	task automatic drain_and_settle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t id, input int unsigned value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= id;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// new register setting; a wider image must restart the frame so that
	// no column is read before it was filled
	task automatic start_phase(input int unsigned kr, input int unsigned kc,
			input int unsigned gaps, input int unsigned w, input int unsigned h,
			output bit need_fs);
		int unsigned old_w;
		drain_and_settle();
		old_w = clip(img_w, 2, DEF_MAX_IMAGE_WIDTH);
		need_fs = clip(w & 32'h1FFF, 2, DEF_MAX_IMAGE_WIDTH) > old_w;
		write_reg(REG_KERNEL_ROWS, kr);
		write_reg(REG_KERNEL_COLS, kc);
		write_reg(REG_MAX_GAPS, gaps);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		phases++;
	endtask

	task automatic stream_pixels(input int n, input int density, input bit first_fs,
			input bit noisy);
		in_item_t px;
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 79) == 0) hold_until_drained();
			px.is_edge = ($urandom_range(1, 100) <= density);
			px.frame_start = (i == 0) ? first_fs : (noisy && $urandom_range(0, 149) == 0);
			send_pixel(px, 1'b0, '0);
		end
	endtask

	function automatic void add_row(input stim_row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	function automatic stim_row_t wr_row(input cfg_reg_t id, input int unsigned value);
		stim_row_t r;
		r = '{kind: ROW_WRITE, reg_id: id, value: value[CFG_DATA_W-1:0],
			px: '0, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic stim_row_t px_row(input bit pix, input bit fs);
		stim_row_t r;
		r = '{kind: ROW_PIXEL, reg_id: REG_KERNEL_ROWS, value: '0,
			px: in_item_t'{pix, fs}, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic stim_row_t px_check(input bit pix, input bit fs, input out_item_t want);
		stim_row_t r;
		r = px_row(pix, fs);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic int unsigned pick_kernel();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 8191);
			1: return $urandom_range(6, 32);
			default: return $urandom_range(2, 5);
		endcase
	endfunction

	initial begin
		bit need_fs;
		int unsigned kr, kc, gaps, w, h;
		int density, n, rand_pixels;

		// model state after reset
		foreach (col_words[i]) col_words[i] = '0;
		foreach (win_words[i]) win_words[i] = '0;
		pix_row = 0;
		pix_col = 0;
		k_rows = RST_KERNEL_ROWS;
		k_cols = RST_KERNEL_COLS;
		gap_limit = RST_MAX_GAPS;
		img_w = RST_IMAGE_WIDTH;
		img_h = RST_IMAGE_HEIGHT;

		// 3x2 image, 2x2 kernel, no gaps allowed
		add_row(wr_row(REG_KERNEL_ROWS, 2));
		add_row(wr_row(REG_KERNEL_COLS, 2));
		add_row(wr_row(REG_MAX_GAPS, 0));
		add_row(wr_row(REG_IMAGE_WIDTH, 3));
		add_row(wr_row(REG_IMAGE_HEIGHT, 2));
		// full edge frame: both corners complete
		add_row(px_row(1'b1, 1'b1));
		add_row(px_row(1'b1, 1'b0));
		add_row(px_row(1'b1, 1'b0));
		add_row(px_row(1'b1, 1'b0));
		add_row(px_check(1'b1, 1'b0, out_item_t'{12'd0, 12'd0, 6'd3, 6'd3, 1'b0}));
		add_row(px_check(1'b1, 1'b0, out_item_t'{12'd0, 12'd1, 6'd3, 6'd3, 1'b1}));
		// empty frame entered by wrap, no frame_start
		add_row(px_row(1'b0, 1'b0));
		add_row(px_row(1'b0, 1'b0));
		add_row(px_row(1'b0, 1'b0));
		add_row(px_row(1'b0, 1'b0));
		add_row(px_check(1'b0, 1'b0, out_item_t'{12'd0, 12'd0, 6'd0, 6'd0, 1'b0}));
		add_row(px_check(1'b0, 1'b0, out_item_t'{12'd0, 12'd1, 6'd0, 6'd0, 1'b1}));
		// largest gap limit, mixed pixels
		add_row(wr_row(REG_MAX_GAPS, 63));
		add_row(px_row(1'b1, 1'b1));
		add_row(px_row(1'b0, 1'b0));
		add_row(px_row(1'b1, 1'b0));
		add_row(px_row(1'b0, 1'b0));
		add_row(px_row(1'b1, 1'b0));
		// out of range kernel values clamp; kernel wider than image scores nothing
		add_row(wr_row(REG_KERNEL_ROWS, 0));
		add_row(wr_row(REG_KERNEL_COLS, 13'h1FFF));
		add_row(px_row(1'b1, 1'b1));
		add_row(px_row(1'b1, 1'b0));
		// shrinking the width while the column counter is past it
		add_row(wr_row(REG_KERNEL_COLS, 1));
		add_row(wr_row(REG_IMAGE_HEIGHT, 3));
		add_row(px_row(1'b1, 1'b1));
		add_row(px_row(1'b0, 1'b0));
		add_row(px_row(1'b1, 1'b0));
		add_row(px_row(1'b1, 1'b0));
		add_row(px_row(1'b1, 1'b0));
		add_row(wr_row(REG_IMAGE_WIDTH, 2));
		add_row(px_row(1'b1, 1'b0));
		add_row(px_row(1'b0, 1'b0));

		// reset
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed sequence
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				if (i > 0 && directed_rows[i-1].kind == ROW_PIXEL) drain_and_settle();
				write_reg(directed_rows[i].reg_id, directed_rows[i].value);
			end else begin
				send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// random settings and pixel streams
		rand_pixels = 0;
		while (rand_pixels < 800) begin
			kr = pick_kernel();
			kc = pick_kernel();
			case ($urandom_range(0, 9))
				0: gaps = $urandom_range(0, 8191);
				1: gaps = 63;
				2, 3: gaps = $urandom_range(0, 12);
				default: gaps = $urandom_range(0, 3);
			endcase
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 8191);
				1, 2: w = $urandom_range(25, 64);
				default: w = $urandom_range(2, 24);
			endcase
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 16);
			case ($urandom_range(0, 3))
				0: density = 50;
				1: density = 85;
				2: density = 95;
				default: density = 100;
			endcase
			start_phase(kr, kc, gaps, w, h, need_fs);
			quiet = ($urandom_range(0, 3) == 0);
			n = $urandom_range(60, 200);
			stream_pixels(n, density, need_fs || $urandom_range(0, 1), 1'b1);
			rand_pixels += n;
		end

		// tallest kernel on a two-column image: vertical arm at its longest
		start_phase(DEF_MAX_KERNEL_ROWS, 2, 2, 2, DEF_MAX_KERNEL_ROWS, need_fs);
		quiet = ($urandom_range(0, 1) == 0);
		stream_pixels(2 * DEF_MAX_KERNEL_ROWS, 95, 1'b1, 1'b0);
		// widest kernel on a two-row image: horizontal arm at its longest
		start_phase(2, DEF_MAX_KERNEL_COLS, 2, DEF_MAX_KERNEL_COLS, 2, need_fs);
		quiet = 1'b0;
		stream_pixels(2 * DEF_MAX_KERNEL_COLS, 95, 1'b1, 1'b0);

		// wind down
		drain_and_settle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_scores.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_scores.size()));
		$display("covered %0d pixels over %0d random and sized register settings,",
			pixels_in, phases);
		$display("%0d window scores compared, %0d mismatches", windows_out, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/ckgs_pkg.sv
rtl/corner_kernel_gap_score_core.sv
tb/tb_corner_kernel_gap_score_core.sv
